### rtl/two_pass_rms_normalizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-pass RMS normalizer
// Shared clocking and assertion forms for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef TWO_PASS_RMS_NORMALIZER_ASSERT_SVH
`define TWO_PASS_RMS_NORMALIZER_ASSERT_SVH
`define RMS_ON_CLK @(posedge clk) disable iff (!rst_n)
`define RMS_ASSERT(label, prop, msg) \
    label: assert property (`RMS_ON_CLK prop) else $error(msg);
`endif

### rtl/rms_norm_pkg.sv
// ----------------------------------------------------------------------------
// RMS normalizer package
// Sizes, command codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package rms_norm_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int SAMPLE_W    = 16;
    localparam int SQ_W        = 2 * SAMPLE_W - 1;
    localparam int ENERGY_W    = SQ_W + CNT_W;
    localparam int SHIFT_K     = 50 - 2 * SAMPLE_W;
    localparam int TARGET_W    = 16;
    localparam int GAIN_W      = 32;
    localparam int FRAC_W      = 24;
    localparam int DIV_NUM_W   = 64;
    localparam int DIV_DEN_W   = DIV_NUM_W - FRAC_W;
    localparam int ROOT_W      = DIV_NUM_W / 2;
    localparam int EPS_Q24     = 17;
    localparam int INV_SHIFT   = 48;
    localparam int PADDR_W     = 3;
    localparam logic REG_TARGET = 1'b0;
    localparam logic [TARGET_W-1:0] TARGET_RESET = 16'd3685;

    localparam int OP_W = 5;
    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_NONE      = 5'd0;
    localparam op_t OP_LOAD      = 5'd1;
    localparam op_t OP_DIV_M1    = 5'd2;
    localparam op_t OP_SQRT      = 5'd3;
    localparam op_t OP_DIV_G1    = 5'd4;
    localparam op_t OP_LOUD_INIT = 5'd5;
    localparam op_t OP_LOUD_SQ   = 5'd6;
    localparam op_t OP_LOUD_CMP  = 5'd7;
    localparam op_t OP_DIV_M2    = 5'd8;
    localparam op_t OP_AMUL      = 5'd9;
    localparam op_t OP_DIV_G2    = 5'd10;
    localparam op_t OP_TMUL      = 5'd11;
    localparam op_t OP_DIV_INV   = 5'd12;
    localparam op_t OP_INV_SET   = 5'd13;
    localparam op_t OP_DMUL      = 5'd14;
    localparam op_t OP_DOUT      = 5'd15;
    localparam op_t OP_EMPTY     = 5'd16;

    typedef struct packed {
        op_t  op;
        logic new_clip;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic sqrt_busy;
        logic ptr_end;
        logic ptr_last;
        logic loud_zero;
        logic out_busy;
    } sts_t;

    function automatic logic [GAIN_W-1:0] sat32(input logic [DIV_NUM_W-1:0] v);
        sat32 = (v[DIV_NUM_W-1:GAIN_W] != '0) ? '1 : v[GAIN_W-1:0];
    endfunction

endpackage

### rtl/rms_norm_if.sv
// ----------------------------------------------------------------------------
// RMS normalizer channels
// Request channels for input items and result items.
// ----------------------------------------------------------------------------
interface rms_norm_in_if import rms_norm_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clip_end;

    modport source (output valid, mode, sample, clip_end, input ready);
    modport sink (input valid, mode, sample, clip_end, output ready);
endinterface

interface rms_norm_out_if import rms_norm_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic [GAIN_W-1:0]          restore_gain;
    logic                       final_sample;
    logic                       saturated;
    logic                       empty_clip;
    logic                       dropped;

    modport source (output valid, out_sample, restore_gain, final_sample, saturated,
                    empty_clip, dropped, input ready);
    modport sink (input valid, out_sample, restore_gain, final_sample, saturated,
                  empty_clip, dropped, output ready);
endinterface

### rtl/rms_norm_div.sv
// ----------------------------------------------------------------------------
// RMS normalizer divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rms_norm_div import rms_norm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 busy,
    output logic [DIV_NUM_W-1:0] quo
);

    localparam int CW = $clog2(DIV_NUM_W + 1);

    logic [CW-1:0]        cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    assign rem_sh = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign busy   = cnt_reg != '0;
    assign quo    = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(DIV_NUM_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy)
        begin
            rem_reg <= ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], ge};
        end
    end

endmodule

### rtl/rms_norm_sqrt.sv
// ----------------------------------------------------------------------------
// RMS normalizer square root
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rms_norm_sqrt import rms_norm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] val,
    output logic                 busy,
    output logic [ROOT_W-1:0]    root
);

    localparam int CW = $clog2(ROOT_W + 1);
    localparam int RW = ROOT_W + 2;

    logic [CW-1:0]        cnt_reg;
    logic [DIV_NUM_W-1:0] v_reg;
    logic [RW-1:0]        rem_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [RW+1:0]        rem_sh;
    logic [RW+1:0]        trial;
    logic [RW+1:0]        diff;
    logic                 ge;

    assign rem_sh = {rem_reg, v_reg[DIV_NUM_W-1:DIV_NUM_W-2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;
    assign busy   = cnt_reg != '0;
    assign root   = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(ROOT_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= val;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy)
        begin
            v_reg    <= {v_reg[DIV_NUM_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

endmodule

### rtl/rms_norm_dp.sv
// ----------------------------------------------------------------------------
// RMS normalizer datapath
// Sample store, accumulators, gain arithmetic and result register.
// ----------------------------------------------------------------------------
module rms_norm_dp import rms_norm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output sts_t                       sts,
    input  logic [TARGET_W-1:0]        target_level,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_sample,
    output logic [GAIN_W-1:0]          restore_gain,
    output logic                       final_sample,
    output logic                       saturated,
    output logic                       empty_clip,
    output logic                       dropped
);

    localparam int PW = SAMPLE_W + GAIN_W + 1;
    localparam int QW = PW - FRAC_W;

    logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];

    logic [CNT_W-1:0]           count_reg;
    logic [ENERGY_W-1:0]        energy_reg;
    logic [ENERGY_W-1:0]        loud_e_reg;
    logic [CNT_W-1:0]           loud_n_reg;
    logic                       ovf_reg;
    logic [CNT_W-1:0]           ptr_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] mem_q_reg;
    logic [GAIN_W-1:0]          g1_reg;
    logic [DIV_DEN_W-1:0]       a_reg;
    logic [GAIN_W-1:0]          tg_reg;
    logic [GAIN_W-1:0]          inv_reg;
    logic [SQ_W-1:0]            sq_reg;
    logic signed [PW-1:0]       p_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic [GAIN_W-1:0]          restore_reg;
    logic                       final_reg;
    logic                       sat_reg;
    logic                       empty_reg;
    logic                       dropped_reg;

    logic signed [2*SAMPLE_W-1:0] in_prod;
    logic signed [2*SAMPLE_W-1:0] mq_prod;
    logic [CNT_W-1:0]             base_cnt;
    logic [ENERGY_W-1:0]          base_e;
    logic                         base_ovf;
    logic                         can_store;
    logic                         div_start;
    logic                         div_busy;
    logic [DIV_NUM_W-1:0]         div_num;
    logic [DIV_DEN_W-1:0]         div_den;
    logic [DIV_NUM_W-1:0]         quo;
    logic                         sqrt_busy;
    logic [ROOT_W-1:0]            root;
    logic [ROOT_W-1:0]            rl;
    logic [DIV_NUM_W-1:0]         amul_prod;
    logic [GAIN_W-1:0]            g2;
    logic [DIV_NUM_W-1:0]         tmul_prod;
    logic [ENERGY_W-1:0]          cmp_prod;
    logic signed [PW-1:0]         p_next;
    logic signed [PW-1:0]         rnd;
    logic signed [QW-1:0]         q_full;
    logic                         q_hi;
    logic                         q_lo;
    logic signed [SAMPLE_W-1:0]   q_sat;

    assign in_prod   = sample * sample;
    assign mq_prod   = mem_q_reg * mem_q_reg;
    assign base_cnt  = cmd.new_clip ? '0 : count_reg;
    assign base_e    = cmd.new_clip ? '0 : energy_reg;
    assign base_ovf  = cmd.new_clip ? 1'b0 : ovf_reg;
    assign can_store = base_cnt != CNT_W'(MAX_SAMPLES);

    always_comb
    begin
        div_start = 1'b1;
        div_num   = '0;
        div_den   = '0;
        case (cmd.op)
            OP_DIV_M1:
            begin
                div_num = DIV_NUM_W'(energy_reg) << SHIFT_K;
                div_den = DIV_DEN_W'(count_reg);
            end
            OP_DIV_G1:
            begin
                div_num = DIV_NUM_W'(target_level) << GAIN_W;
                div_den = DIV_DEN_W'(root) + DIV_DEN_W'(EPS_Q24);
            end
            OP_DIV_M2:
            begin
                div_num = DIV_NUM_W'(loud_e_reg) << SHIFT_K;
                div_den = DIV_DEN_W'(loud_n_reg);
            end
            OP_DIV_G2:
            begin
                div_num = DIV_NUM_W'(target_level) << GAIN_W;
                div_den = a_reg + DIV_DEN_W'(EPS_Q24);
            end
            OP_DIV_INV:
            begin
                div_num = DIV_NUM_W'(1) << INV_SHIFT;
                div_den = DIV_DEN_W'(tg_reg) + DIV_DEN_W'(EPS_Q24);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    rms_norm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (quo)
    );

    rms_norm_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_SQRT),
        .val   (quo),
        .busy  (sqrt_busy),
        .root  (root)
    );

    assign rl        = (loud_n_reg == '0) ? '0 : root;
    assign amul_prod = DIV_NUM_W'(g1_reg) * DIV_NUM_W'(rl);
    assign g2        = sat32(quo);
    assign tmul_prod = DIV_NUM_W'(g1_reg) * DIV_NUM_W'(g2);
    assign cmp_prod  = ENERGY_W'(sq_reg) * ENERGY_W'(count_reg);
    assign p_next    = PW'(mem_q_reg) * $signed({1'b0, tg_reg});
    assign rnd       = p_reg + (PW'(1) <<< (FRAC_W - 1));
    assign q_full    = rnd[PW-1:FRAC_W];
    assign q_hi      = q_full > QW'((1 << (SAMPLE_W - 1)) - 1);
    assign q_lo      = q_full < -QW'(1 << (SAMPLE_W - 1));

    always_comb
    begin
        priority if (q_hi)
        begin
            q_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else if (q_lo)
        begin
            q_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            q_sat = q_full[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD && can_store)
        begin
            mem[base_cnt[ADDR_W-1:0]] <= sample;
        end
        mem_q_reg <= mem[ptr_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            energy_reg    <= '0;
            loud_e_reg    <= '0;
            loud_n_reg    <= '0;
            ovf_reg       <= 1'b0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ready && cmd.op != OP_DOUT && cmd.op != OP_EMPTY)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_LOAD:
                begin
                    if (cmd.new_clip)
                    begin
                        loud_e_reg <= '0;
                        loud_n_reg <= '0;
                        ptr_reg    <= '0;
                    end
                    if (can_store)
                    begin
                        count_reg  <= base_cnt + CNT_W'(1);
                        energy_reg <= base_e + ENERGY_W'(in_prod[SQ_W-1:0]);
                        ovf_reg    <= base_ovf;
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                OP_LOUD_INIT:
                begin
                    loud_e_reg <= '0;
                    loud_n_reg <= '0;
                    ptr_reg    <= '0;
                end
                OP_LOUD_CMP:
                begin
                    if (cmp_prod > energy_reg)
                    begin
                        loud_e_reg <= loud_e_reg + ENERGY_W'(sq_reg);
                        loud_n_reg <= loud_n_reg + CNT_W'(1);
                    end
                    ptr_reg <= ptr_reg + CNT_W'(1);
                end
                OP_INV_SET:
                begin
                    ptr_reg <= '0;
                end
                OP_DOUT:
                begin
                    ptr_reg       <= ptr_reg + CNT_W'(1);
                    out_valid_reg <= 1'b1;
                end
                OP_EMPTY:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOUD_INIT:
            begin
                g1_reg <= sat32(quo);
            end
            OP_LOUD_SQ:
            begin
                sq_reg <= mq_prod[SQ_W-1:0];
            end
            OP_AMUL:
            begin
                a_reg <= amul_prod[DIV_NUM_W-1:FRAC_W];
            end
            OP_TMUL:
            begin
                tg_reg <= sat32(tmul_prod >> FRAC_W);
            end
            OP_INV_SET:
            begin
                inv_reg <= sat32(quo);
            end
            OP_DMUL:
            begin
                p_reg <= p_next;
            end
            OP_DOUT:
            begin
                out_sample_reg <= q_sat;
                restore_reg    <= inv_reg;
                final_reg      <= sts.ptr_last;
                sat_reg        <= q_hi | q_lo;
                empty_reg      <= 1'b0;
                dropped_reg    <= ovf_reg;
            end
            OP_EMPTY:
            begin
                out_sample_reg <= '0;
                restore_reg    <= '0;
                final_reg      <= 1'b1;
                sat_reg        <= 1'b0;
                empty_reg      <= 1'b1;
                dropped_reg    <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign sts.div_busy  = div_busy;
    assign sts.sqrt_busy = sqrt_busy;
    assign sts.ptr_end   = ptr_reg == count_reg;
    assign sts.ptr_last  = (ptr_reg + CNT_W'(1)) == count_reg;
    assign sts.loud_zero = loud_n_reg == '0;
    assign sts.out_busy  = out_valid_reg & ~out_ready;

    assign out_valid    = out_valid_reg;
    assign out_sample   = out_sample_reg;
    assign restore_gain = restore_reg;
    assign final_sample = final_reg;
    assign saturated    = sat_reg;
    assign empty_clip   = empty_reg;
    assign dropped      = dropped_reg;

endmodule

### rtl/rms_norm_ctrl.sv
// ----------------------------------------------------------------------------
// RMS normalizer controller
// Sequences loading, clip analysis and draining of one clip.
// ----------------------------------------------------------------------------
module rms_norm_ctrl import rms_norm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_mode,
    input  logic in_clip_end,
    output logic in_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_M1    = 5'd1;
    localparam logic [4:0] S_M1W   = 5'd2;
    localparam logic [4:0] S_R1    = 5'd3;
    localparam logic [4:0] S_R1W   = 5'd4;
    localparam logic [4:0] S_G1    = 5'd5;
    localparam logic [4:0] S_G1W   = 5'd6;
    localparam logic [4:0] S_LINIT = 5'd7;
    localparam logic [4:0] S_LRD   = 5'd8;
    localparam logic [4:0] S_LSQ   = 5'd9;
    localparam logic [4:0] S_LCMP  = 5'd10;
    localparam logic [4:0] S_M2    = 5'd11;
    localparam logic [4:0] S_M2W   = 5'd12;
    localparam logic [4:0] S_R2    = 5'd13;
    localparam logic [4:0] S_R2W   = 5'd14;
    localparam logic [4:0] S_AMUL  = 5'd15;
    localparam logic [4:0] S_G2    = 5'd16;
    localparam logic [4:0] S_G2W   = 5'd17;
    localparam logic [4:0] S_TMUL  = 5'd18;
    localparam logic [4:0] S_INV   = 5'd19;
    localparam logic [4:0] S_INVW  = 5'd20;
    localparam logic [4:0] S_DRD   = 5'd21;
    localparam logic [4:0] S_DMUL  = 5'd22;
    localparam logic [4:0] S_DOUT  = 5'd23;
    localparam logic [4:0] S_EMPTY = 5'd24;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_LOAD  = 2'd1;
    localparam logic [1:0] PH_DRAIN = 2'd2;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic       pend_reg;
    logic       pend_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        cmd        = '{op: OP_NONE, new_clip: 1'b0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!in_mode)
                    begin
                        cmd.op       = OP_LOAD;
                        cmd.new_clip = phase_reg != PH_LOAD;
                        phase_next   = PH_LOAD;
                        if (in_clip_end)
                        begin
                            state_next = S_M1;
                            pend_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        priority if (phase_reg == PH_LOAD)
                        begin
                            state_next = S_M1;
                            pend_next  = 1'b1;
                        end
                        else if (phase_reg == PH_DRAIN)
                        begin
                            state_next = S_DRD;
                        end
                        else
                        begin
                            state_next = S_EMPTY;
                        end
                    end
                end
            end
            S_M1:
            begin
                cmd.op     = OP_DIV_M1;
                state_next = S_M1W;
            end
            S_M1W:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_R1;
                end
            end
            S_R1:
            begin
                cmd.op     = OP_SQRT;
                state_next = S_R1W;
            end
            S_R1W:
            begin
                if (!sts.sqrt_busy)
                begin
                    state_next = S_G1;
                end
            end
            S_G1:
            begin
                cmd.op     = OP_DIV_G1;
                state_next = S_G1W;
            end
            S_G1W:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_LINIT;
                end
            end
            S_LINIT:
            begin
                cmd.op     = OP_LOUD_INIT;
                state_next = S_LRD;
            end
            S_LRD:
            begin
                priority if (!sts.ptr_end)
                begin
                    state_next = S_LSQ;
                end
                else if (sts.loud_zero)
                begin
                    state_next = S_AMUL;
                end
                else
                begin
                    state_next = S_M2;
                end
            end
            S_LSQ:
            begin
                cmd.op     = OP_LOUD_SQ;
                state_next = S_LCMP;
            end
            S_LCMP:
            begin
                cmd.op     = OP_LOUD_CMP;
                state_next = S_LRD;
            end
            S_M2:
            begin
                cmd.op     = OP_DIV_M2;
                state_next = S_M2W;
            end
            S_M2W:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_R2;
                end
            end
            S_R2:
            begin
                cmd.op     = OP_SQRT;
                state_next = S_R2W;
            end
            S_R2W:
            begin
                if (!sts.sqrt_busy)
                begin
                    state_next = S_AMUL;
                end
            end
            S_AMUL:
            begin
                cmd.op     = OP_AMUL;
                state_next = S_G2;
            end
            S_G2:
            begin
                cmd.op     = OP_DIV_G2;
                state_next = S_G2W;
            end
            S_G2W:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_TMUL;
                end
            end
            S_TMUL:
            begin
                cmd.op     = OP_TMUL;
                state_next = S_INV;
            end
            S_INV:
            begin
                cmd.op     = OP_DIV_INV;
                state_next = S_INVW;
            end
            S_INVW:
            begin
                if (!sts.div_busy)
                begin
                    cmd.op     = OP_INV_SET;
                    phase_next = PH_DRAIN;
                    state_next = pend_reg ? S_DRD : S_IDLE;
                end
            end
            S_DRD:
            begin
                state_next = S_DMUL;
            end
            S_DMUL:
            begin
                cmd.op     = OP_DMUL;
                state_next = S_DOUT;
            end
            S_DOUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.op     = OP_DOUT;
                    state_next = S_IDLE;
                    if (sts.ptr_last)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            S_EMPTY:
            begin
                if (!sts.out_busy)
                begin
                    cmd.op     = OP_EMPTY;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

### rtl/two_pass_rms_normalizer.sv
// ----------------------------------------------------------------------------
// Two-pass RMS normalizer
// Loads a clip, derives two loudness gains and drains the scaled clip.
// ----------------------------------------------------------------------------
// Closing a clip runs up to five divisions on the shared bit-serial divider,
// up to two square roots, and a loud-sample scan that reads, squares and
// compares each stored sample through the sample memory; no request is
// taken meanwhile. Each drain request passes acceptance, memory read, gain
// multiply and rounding into the result register, and waits at the last
// step while the previous result has not been taken.
module two_pass_rms_normalizer import rms_norm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    rms_norm_in_if.sink        din,
    rms_norm_out_if.source     dout,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [TARGET_W-1:0] target_reg;
    logic                reg_hit;
    cmd_t                cmd;
    sts_t                sts;

    assign pready  = 1'b1;
    assign reg_hit = paddr[PADDR_W-1] == REG_TARGET;
    assign prdata  = reg_hit ? 32'(target_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            target_reg <= pwdata[TARGET_W-1:0];
        end
    end

    rms_norm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (din.valid),
        .in_mode     (din.mode),
        .in_clip_end (din.clip_end),
        .in_ready    (din.ready),
        .cmd         (cmd),
        .sts         (sts)
    );

    rms_norm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .target_level (target_reg),
        .sample       (din.sample),
        .out_valid    (dout.valid),
        .out_ready    (dout.ready),
        .out_sample   (dout.out_sample),
        .restore_gain (dout.restore_gain),
        .final_sample (dout.final_sample),
        .saturated    (dout.saturated),
        .empty_clip   (dout.empty_clip),
        .dropped      (dout.dropped)
    );

endmodule

### rtl/rms_norm_chk.sv
// ----------------------------------------------------------------------------
// RMS normalizer checker
// Port-level properties of the normalizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_pass_rms_normalizer_assert.svh"

module rms_norm_chk import rms_norm_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       in_mode,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [SAMPLE_W-1:0] out_sample,
    input logic [GAIN_W-1:0]          restore_gain,
    input logic                       final_sample,
    input logic                       saturated,
    input logic                       empty_clip,
    input logic                       dropped
);

    // A pending result stays offered until it is taken.
    `RMS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result withdrawn")

    // A load request never produces a result of its own.
    `RMS_ASSERT(a_load_quiet, in_valid && in_ready && !in_mode && !out_valid |=> !out_valid, "load made a result")

    `RMS_ASSERT(a_empty_fields, out_valid && empty_clip |-> out_sample == '0 && restore_gain == '0 && final_sample && !saturated && !dropped, "bad empty result")

    `RMS_ASSERT(a_sat_range, out_valid && saturated |-> out_sample == {1'b0, {(SAMPLE_W-1){1'b1}}} || out_sample == {1'b1, {(SAMPLE_W-1){1'b0}}}, "saturated value off range")

endmodule

bind two_pass_rms_normalizer rms_norm_chk u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (din.valid),
    .in_ready     (din.ready),
    .in_mode      (din.mode),
    .out_valid    (dout.valid),
    .out_ready    (dout.ready),
    .out_sample   (dout.out_sample),
    .restore_gain (dout.restore_gain),
    .final_sample (dout.final_sample),
    .saturated    (dout.saturated),
    .empty_clip   (dout.empty_clip),
    .dropped      (dout.dropped)
);

### sim/two_pass_rms_normalizer_test.sv
// ----------------------------------------------------------------------------
// Two-pass RMS normalizer testbench
// Streams load and drain requests with bursty input and a stalling output,
// predicts every drained sample, gain and flag, and compares them in order.
// ----------------------------------------------------------------------------
module two_pass_rms_normalizer_test;
    import rms_norm_pkg::*;

    typedef struct {
        logic                       mode;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clip_end;
    } request_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic [GAIN_W-1:0]          restore_gain;
        logic                       final_sample;
        logic                       saturated;
        logic                       empty_clip;
        logic                       dropped;
    } drained_t;

    typedef enum logic [1:0] {CLIP_IDLE, CLIP_LOADING, CLIP_DRAINING} clip_phase_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    rms_norm_in_if  din_ch ();
    rms_norm_out_if dout_ch ();

    two_pass_rms_normalizer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din_ch),
        .dout    (dout_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    request_t pending_requests[$];
    drained_t expected_samples[$];
    int errors;
    bit took_request;
    int burst_left;
    int gap_left;
    bit long_hold;
    bit random_started;
    int stall_phase;
    logic [15:0] stall_mask;
    int load_total;

    logic signed [SAMPLE_W-1:0] clip_mem [MAX_SAMPLES];
    int unsigned clip_len;
    int unsigned loud_n;
    int unsigned rd_ptr;
    logic [63:0] energy;
    logic [63:0] loud_energy;
    logic [63:0] gain_total;
    logic [63:0] gain_inverse;
    clip_phase_t clip_phase;
    bit samples_lost;
    logic [15:0] target_q16;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] mean_scaled(input logic [63:0] sum, input logic [63:0] n);
        return ((sum / n) << SHIFT_K) + (((sum % n) << SHIFT_K) / n);
    endfunction

    function automatic logic [63:0] clamp32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    function automatic void close_clip_gains();
        logic [63:0] n;
        logic [63:0] r1;
        logic [63:0] g1;
        logic [63:0] rl;
        logic [63:0] a;
        logic [63:0] g2;
        logic [63:0] sq;
        logic [63:0] tgt;
        longint xl;
        n = clip_len;
        rl = 0;
        if (n == 0)
        begin
            clip_phase = CLIP_IDLE;
            return;
        end
        tgt = {16'd0, target_q16, 32'd0};
        r1 = root64(mean_scaled(energy, n));
        g1 = clamp32(tgt / (r1 + EPS_Q24));
        loud_energy = 0;
        loud_n = 0;
        for (int i = 0; i < clip_len; i++)
        begin
            xl = clip_mem[i];
            sq = xl * xl;
            if (sq * n > energy)
            begin
                loud_energy += sq;
                loud_n++;
            end
        end
        if (loud_n != 0)
            rl = root64(mean_scaled(loud_energy, loud_n));
        a = (g1 * rl) >> FRAC_W;
        g2 = clamp32(tgt / (a + EPS_Q24));
        gain_total = clamp32((g1 * g2) >> FRAC_W);
        gain_inverse = clamp32((64'd1 << INV_SHIFT) / (gain_total + EPS_Q24));
        rd_ptr = 0;
        clip_phase = CLIP_DRAINING;
    endfunction

    function automatic void predict_request(input request_t r);
        drained_t d;
        longint xl;
        longint p;
        longint q;
        if (r.mode == 1'b0)
        begin
            if (clip_phase != CLIP_LOADING)
            begin
                clip_len = 0;
                energy = 0;
                loud_energy = 0;
                loud_n = 0;
                samples_lost = 0;
                rd_ptr = 0;
                clip_phase = CLIP_LOADING;
            end
            if (clip_len < MAX_SAMPLES)
            begin
                clip_mem[clip_len] = r.sample;
                clip_len++;
                xl = r.sample;
                energy += 64'(xl * xl);
            end
            else
                samples_lost = 1;
            if (r.clip_end)
                close_clip_gains();
            return;
        end
        if (clip_phase == CLIP_LOADING)
            close_clip_gains();
        d = '{default: 0};
        if (clip_phase != CLIP_DRAINING || rd_ptr >= clip_len)
        begin
            d.final_sample = 1;
            d.empty_clip = 1;
            expected_samples.insert(expected_samples.size(), d);
            return;
        end
        xl = clip_mem[rd_ptr];
        p = xl * longint'(gain_total) + (longint'(1) << 23);
        q = p >>> FRAC_W;
        if (q > 32767)
        begin
            q = 32767;
            d.saturated = 1;
        end
        if (q < -32768)
        begin
            q = -32768;
            d.saturated = 1;
        end
        d.out_sample = q[SAMPLE_W-1:0];
        d.restore_gain = gain_inverse[GAIN_W-1:0];
        d.final_sample = (rd_ptr + 1 == clip_len);
        d.dropped = samples_lost;
        rd_ptr++;
        if (d.final_sample)
            clip_phase = CLIP_IDLE;
        expected_samples.insert(expected_samples.size(), d);
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("Mismatch on %s at %0t: got %0h, expected %0h", field, $time, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        took_request = 0;
        if (rst_n && din_ch.valid && din_ch.ready)
        begin
            predict_request('{din_ch.mode, din_ch.sample, din_ch.clip_end});
            void'(pending_requests.pop_front());
            took_request = 1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !(din_ch.valid && !took_request))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                din_ch.valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                din_ch.valid <= 1'b1;
                din_ch.mode <= pending_requests[0].mode;
                din_ch.sample <= pending_requests[0].sample;
                din_ch.clip_end <= pending_requests[0].clip_end;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(40);
                    gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                end
            end
            else
                din_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            stall_phase = (stall_phase + 1) % 16;
            if (stall_phase == 0 && $urandom_range(7) == 0)
                stall_mask = ($urandom_range(2) == 0) ? 16'hFFFF : 16'($urandom);
            dout_ch.ready <= !long_hold && stall_mask[stall_phase];
        end
    end

    always @(posedge clk)
    begin
        drained_t want;
        if (rst_n && dout_ch.valid && dout_ch.ready)
        begin
            if (expected_samples.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = expected_samples.pop_front();
                if (dout_ch.out_sample !== want.out_sample)
                    report_mismatch("out_sample", dout_ch.out_sample, want.out_sample);
                if (dout_ch.restore_gain !== want.restore_gain)
                    report_mismatch("restore_gain", dout_ch.restore_gain, want.restore_gain);
                if (dout_ch.final_sample !== want.final_sample)
                    report_mismatch("final_sample", dout_ch.final_sample, want.final_sample);
                if (dout_ch.saturated !== want.saturated)
                    report_mismatch("saturated", dout_ch.saturated, want.saturated);
                if (dout_ch.empty_clip !== want.empty_clip)
                    report_mismatch("empty_clip", dout_ch.empty_clip, want.empty_clip);
                if (dout_ch.dropped !== want.dropped)
                    report_mismatch("dropped", dout_ch.dropped, want.dropped);
            end
        end
    end

    task automatic write_target(input logic [15:0] level);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * REG_TARGET);
        pwdata <= {16'd0, level};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        target_q16 = level;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || din_ch.valid || expected_samples.size() != 0)
            @(posedge clk);
        repeat (3 * MAX_SAMPLES + 600) @(posedge clk);
    endtask

    task automatic push_load(input logic signed [SAMPLE_W-1:0] s, input logic last);
        pending_requests.insert(pending_requests.size(), request_t'{1'b0, s, last});
        load_total++;
    endtask

    task automatic push_drain(input int count);
        repeat (count)
            pending_requests.insert(pending_requests.size(),
                                    request_t'{1'b1, SAMPLE_W'($urandom), 1'($urandom)});
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample(input int shift);
        logic signed [SAMPLE_W-1:0] s;
        s = SAMPLE_W'($urandom);
        s = s >>> shift;
        if ($urandom_range(15) == 0)
            s = ($urandom_range(1) == 0) ? 16'sh7FFF : 16'sh8000;
        return s;
    endfunction

    task automatic push_random_clips(input int loads);
        int n;
        int shift;
        int kind;
        int stop_at;
        stop_at = load_total + loads;
        while (load_total < stop_at)
        begin
            kind = $urandom_range(19);
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 24);
            shift = $urandom_range(15);
            if (kind == 0)
            begin
                repeat ($urandom_range(1, 6))
                    pending_requests.insert(pending_requests.size(),
                                            request_t'{1'($urandom), SAMPLE_W'($urandom),
                                                       1'($urandom)});
            end
            else
            begin
                for (int i = 0; i < n; i++)
                    push_load(random_sample(shift), (kind > 2) && (i == n - 1));
                if (kind == 1)
                    push_drain($urandom_range(0, n - 1));
                else
                    push_drain(n + (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0));
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        din_ch.valid = 1'b0;
        din_ch.mode = 1'b0;
        din_ch.sample = '0;
        din_ch.clip_end = 1'b0;
        dout_ch.ready = 1'b0;
        stall_mask = 16'hFFFF;
        target_q16 = TARGET_RESET;
        clip_phase = CLIP_IDLE;
        clip_len = 0;
        loud_n = 0;
        rd_ptr = 0;
        energy = 0;
        loud_energy = 0;
        gain_total = 0;
        gain_inverse = 0;
        samples_lost = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_drain(1);
        push_load(16'sh7FFF, 1'b1);
        push_drain(2);
        push_load(16'sh8000, 1'b0);
        push_load(16'sh0000, 1'b0);
        push_load(16'sh0001, 1'b0);
        push_load(16'shFFFF, 1'b1);
        push_drain(4);
        push_load(16'sh4000, 1'b0);
        push_load(-16'sh2000, 1'b0);
        push_drain(3);
        push_load(16'sh0000, 1'b0);
        push_load(16'sh0000, 1'b1);
        push_drain(1);
        push_load(16'sh0123, 1'b1);
        push_drain(1);
        wait_idle();

        write_target(16'hFFFF);
        push_load(16'sh0001, 1'b0);
        push_load(16'sh7FFF, 1'b0);
        push_load(-16'sh0004, 1'b1);
        push_drain(3);
        random_started = 1;
        push_random_clips(150);
        wait_idle();

        write_target(16'h0001);
        push_random_clips(120);
        wait_idle();

        write_target(16'($urandom_range(1, 65535)));
        push_random_clips(200);
        wait_idle();

        write_target(TARGET_RESET);
        push_random_clips(150);
        while (pending_requests.size() != 0 || din_ch.valid || expected_samples.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        wait (random_started);
        repeat ($urandom_range(100, 600)) @(posedge clk);
        long_hold = 1;
        repeat (4000) @(posedge clk);
        long_hold = 0;
    end

    initial
    begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end
endmodule

### two_pass_rms_normalizer.f
+incdir+rtl
rtl/rms_norm_pkg.sv
rtl/rms_norm_if.sv
rtl/rms_norm_div.sv
rtl/rms_norm_sqrt.sv
rtl/rms_norm_dp.sv
rtl/rms_norm_ctrl.sv
rtl/two_pass_rms_normalizer.sv
rtl/rms_norm_chk.sv
sim/two_pass_rms_normalizer_test.sv
